@@ hw/rtl/block_transfer_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Block transfer receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TRANSFER_RECEIVER_DEFINES_SVH
`define BLOCK_TRANSFER_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define BTR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block transfer receiver check failed");

// Next-cycle implication, disabled while reset is high
`define BTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block transfer receiver check failed");

`endif

@@ hw/rtl/btr_pkg.sv @@
// ----------------------------------------------------------------------------
// Block transfer receiver package
// Codes, beat layouts and configuration record shared by the receiver RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btr_pkg;

   // Header tag "FTB" plus version byte, little-endian
   localparam logic [31:0] TAG_VALID = 32'h0142_5446;

   localparam logic [16:0] MAX_BLOCK_RESET = 17'd4096;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_TOTAL_SIZE = 2'd0,
      REG_MAX_BLOCK  = 2'd1,
      REG_DUP_ENABLE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CLS_DATA     = 3'd0,
      CLS_DUP_DATA = 3'd1,
      CLS_END      = 3'd2,
      CLS_DUP_END  = 3'd3,
      CLS_INVALID  = 3'd4,
      CLS_CANCEL   = 3'd5
   } class_type;

   typedef enum logic [1:0] {
      RC_NONE = 2'd0,
      RC_ACK  = 2'd1,
      RC_NAK  = 2'd2,
      RC_CAN  = 2'd3
   } reply_type;

   typedef enum logic [2:0] {
      OUT_APPLIED   = 3'd0,
      OUT_RETRY     = 3'd1,
      OUT_FAILED    = 3'd2,
      OUT_CANCELLED = 3'd3,
      OUT_SYNCED    = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [31:0] total_size;
      logic [16:0] max_block_bytes;
      logic        dup_detect_enable;
   } cfg_type;

   typedef struct packed {
      logic        op;
      logic [31:0] tag_word;
      logic [31:0] block_index;
      logic [31:0] block_length;
      logic [31:0] block_crc;
      logic [31:0] payload_crc;
      logic        store_ok;
   } req_type;

   typedef struct packed {
      class_type   block_class;
      reply_type   reply_code;
      logic [31:0] reply_index;
      logic [31:0] reply_offset;
      outcome_type outcome;
   } rsp_type;

endpackage

@@ hw/rtl/btr_csr.sv @@
// ----------------------------------------------------------------------------
// Block transfer receiver configuration registers
// Write-only register file holding transfer size and acceptance settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output btr_pkg::cfg_type cfg
);

   btr_pkg::cfg_type cfg_ff;
   btr_pkg::cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (btr_pkg::csr_index_type'(csr_index))
            btr_pkg::REG_TOTAL_SIZE: cfg_in.total_size        = csr_wdata;
            btr_pkg::REG_MAX_BLOCK:  cfg_in.max_block_bytes   = csr_wdata[16:0];
            btr_pkg::REG_DUP_ENABLE: cfg_in.dup_detect_enable = csr_wdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_size        <= '0;
         cfg_ff.max_block_bytes   <= btr_pkg::MAX_BLOCK_RESET;
         cfg_ff.dup_detect_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/btr_eval.sv @@
// ----------------------------------------------------------------------------
// Block transfer receiver header evaluation
// Classifies one beat against the progress record, builds the reply and
// commits progress when the beat moves on to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_transfer_receiver_defines.svh"

module btr_eval (
   input  logic             clock,
   input  logic             reset,
   input  btr_pkg::cfg_type cfg,
   input  logic             fire,
   input  btr_pkg::req_type item,
   output btr_pkg::rsp_type rsp
);

   // Progress record
   logic [31:0] next_index_ff,   next_index_in;
   logic [31:0] committed_ff,    committed_in;
   logic [31:0] prior_offset_ff, prior_offset_in;
   logic [31:0] prior_index_ff,  prior_index_in;
   logic [31:0] prior_length_ff, prior_length_in;
   logic [31:0] prior_crc_ff,    prior_crc_in;
   logic        prior_valid_ff,  prior_valid_in;
   logic        done_ff,         done_in;

   btr_pkg::class_type cls;
   logic [31:0]        remaining;
   logic [31:0]        new_committed;
   logic               tag_ok;
   logic               index_next;
   logic               index_dup;
   logic               fits;
   logic               commit_data;
   logic               commit_end;

   // Header classification
   always_comb begin
      remaining     = cfg.total_size - committed_ff;
      new_committed = committed_ff + item.block_length;
      tag_ok        = item.tag_word == btr_pkg::TAG_VALID;
      index_next    = item.block_index == next_index_ff;
      index_dup     = (next_index_ff != '0) && (item.block_index == next_index_ff - 32'd1);
      fits          = (item.block_length <= {15'd0, cfg.max_block_bytes})
                      && (item.block_length <= remaining);

      priority if (!tag_ok) begin
         cls = btr_pkg::CLS_INVALID;
      end else if (item.block_length == '0) begin
         if (!index_next || item.block_crc != '0 || committed_ff != cfg.total_size) begin
            cls = btr_pkg::CLS_INVALID;
         end else if (done_ff) begin
            cls = btr_pkg::CLS_DUP_END;
         end else begin
            cls = btr_pkg::CLS_END;
         end
      end else if (done_ff || item.block_index == '1 || committed_ff > cfg.total_size) begin
         cls = btr_pkg::CLS_INVALID;
      end else if (index_next && fits) begin
         cls = btr_pkg::CLS_DATA;
      end else if (cfg.dup_detect_enable && prior_valid_ff && index_dup
                   && item.block_length == prior_length_ff
                   && item.block_crc == prior_crc_ff) begin
         cls = btr_pkg::CLS_DUP_DATA;
      end else begin
         cls = btr_pkg::CLS_INVALID;
      end
   end

   // Reply selection
   always_comb begin
      commit_data      = 1'b0;
      commit_end       = 1'b0;
      rsp.block_class  = cls;
      rsp.reply_code   = btr_pkg::RC_ACK;
      rsp.reply_index  = item.block_index;
      rsp.reply_offset = committed_ff;
      rsp.outcome      = btr_pkg::OUT_APPLIED;
      if (item.op) begin
         rsp.block_class  = btr_pkg::CLS_CANCEL;
         rsp.reply_code   = btr_pkg::RC_NONE;
         rsp.reply_index  = '0;
         rsp.reply_offset = '0;
         rsp.outcome      = done_ff ? btr_pkg::OUT_SYNCED : btr_pkg::OUT_CANCELLED;
      end else begin
         unique case (cls)
            btr_pkg::CLS_DATA: begin
               if (item.payload_crc != item.block_crc) begin
                  rsp.reply_code = btr_pkg::RC_NAK;
                  rsp.outcome    = btr_pkg::OUT_RETRY;
               end else if (!item.store_ok) begin
                  rsp.reply_code = btr_pkg::RC_CAN;
                  rsp.outcome    = btr_pkg::OUT_FAILED;
               end else begin
                  commit_data      = 1'b1;
                  rsp.reply_offset = new_committed;
               end
            end
            btr_pkg::CLS_DUP_DATA: begin
               rsp.reply_index  = prior_index_ff;
               rsp.reply_offset = prior_offset_ff;
            end
            btr_pkg::CLS_END: begin
               if (!item.store_ok) begin
                  rsp.reply_code = btr_pkg::RC_CAN;
                  rsp.outcome    = btr_pkg::OUT_FAILED;
               end else begin
                  commit_end = 1'b1;
               end
            end
            btr_pkg::CLS_DUP_END: begin
               rsp.reply_code = btr_pkg::RC_ACK;
            end
            default: begin
               rsp.reply_code = btr_pkg::RC_CAN;
               rsp.outcome    = btr_pkg::OUT_FAILED;
            end
         endcase
      end
   end

   // Progress update, taken only when the beat advances
   always_comb begin
      next_index_in   = next_index_ff;
      committed_in    = committed_ff;
      prior_offset_in = prior_offset_ff;
      prior_index_in  = prior_index_ff;
      prior_length_in = prior_length_ff;
      prior_crc_in    = prior_crc_ff;
      prior_valid_in  = prior_valid_ff;
      done_in         = done_ff;
      if (fire && commit_data) begin
         next_index_in   = item.block_index + 32'd1;
         committed_in    = new_committed;
         prior_offset_in = new_committed;
         prior_index_in  = item.block_index;
         prior_length_in = item.block_length;
         prior_crc_in    = item.block_crc;
         prior_valid_in  = 1'b1;
      end
      if (fire && commit_end) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff   <= '0;
         committed_ff    <= '0;
         prior_offset_ff <= '0;
         prior_index_ff  <= '0;
         prior_length_ff <= '0;
         prior_crc_ff    <= '0;
         prior_valid_ff  <= 1'b0;
         done_ff         <= 1'b0;
      end else begin
         next_index_ff   <= next_index_in;
         committed_ff    <= committed_in;
         prior_offset_ff <= prior_offset_in;
         prior_index_ff  <= prior_index_in;
         prior_length_ff <= prior_length_in;
         prior_crc_ff    <= prior_crc_in;
         prior_valid_ff  <= prior_valid_in;
         done_ff         <= done_in;
      end
   end

   // Finalized transfer stays finalized
   `BTR_ASSERT_NEXT(a_done_sticky, clock, reset, done_ff, done_ff)
   // Offset moves only on a committed data block
   `BTR_ASSERT_NEXT(a_commit_only_on_data, clock, reset, !(fire && commit_data), $stable(committed_ff))
   // Committed data block advances the expected index past it
   `BTR_ASSERT_NEXT(a_index_follows, clock, reset, fire && commit_data, next_index_ff == $past(item.block_index) + 32'd1)
   // Committed offset never passes the configured total on a commit
   `BTR_ASSERT_NOW(a_commit_in_range, clock, reset, fire && commit_data, new_committed <= cfg.total_size)

endmodule

@@ hw/rtl/block_transfer_receiver.sv @@
// ----------------------------------------------------------------------------
// Block transfer receiver
// Checks block headers and cancel bytes of a block transfer, answers each
// header with ACK, NAK or CAN plus the block index and committed byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per received header or sender cancel byte.
//   rsp_* returns exactly one result beat per request beat, in order.
//   csr_* writes total_size (0), max_block_bytes (1), dup_detect_enable (2);
//   write only while no beat is in flight.
// Path: input register, evaluation, then the result register driving rsp_*.
// Throughput: one beat per cycle while rsp_tready is high; the progress
//   record is read and updated within the single evaluation stage, so
//   back-to-back beats see each other's commits.
// Reset (synchronous) clears the progress record and the valid flags of both
//   stage registers, and restores the configuration defaults (size 0,
//   4096-byte blocks, duplicate detection on).
// Backpressure: while rsp_tready is low a held result stays on rsp_*, one
//   more beat waits in the input register, and req_tready then drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_transfer_receiver_defines.svh"

module block_transfer_receiver (
   input  logic          clock,
   input  logic          reset,
   // Request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: tag_word, block_index, block_length, block_crc, payload_crc,
   //        store_ok, then zero fill
   input  logic [167:0]  req_tdata,
   // tuser: op
   input  logic          req_tuser,
   // Result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: reply_code, reply_index, reply_offset, outcome, then zero fill
   output logic [71:0]   rsp_tdata,
   // tuser: block_class
   output logic [2:0]    rsp_tuser,
   // Configuration write port
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata
);

   btr_pkg::cfg_type cfg;
   btr_pkg::req_type req_item;
   btr_pkg::rsp_type eval_rsp;

   logic             in_valid_ff, in_valid_in;
   btr_pkg::req_type in_item_ff,  in_item_in;
   logic             out_valid_ff, out_valid_in;
   btr_pkg::rsp_type out_rsp_ff,   out_rsp_in;
   logic             advance;

   btr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Request beat unpacking
   always_comb begin
      req_item.op           = req_tuser;
      req_item.tag_word     = req_tdata[31:0];
      req_item.block_index  = req_tdata[63:32];
      req_item.block_length = req_tdata[95:64];
      req_item.block_crc    = req_tdata[127:96];
      req_item.payload_crc  = req_tdata[159:128];
      req_item.store_ok     = req_tdata[160];
   end

   // Stage handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   btr_eval u_eval (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (advance),
      .item  (in_item_ff),
      .rsp   (eval_rsp)
   );

   // Input and result register next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = eval_rsp;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

   // Result beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rsp_ff.block_class;
   assign rsp_tdata  = {3'd0, out_rsp_ff.outcome, out_rsp_ff.reply_offset,
                        out_rsp_ff.reply_index, out_rsp_ff.reply_code};

   // An empty result register always frees the request side
   `BTR_ASSERT_NOW(a_ready_when_empty, clock, reset, !out_valid_ff, req_tready)

endmodule
